>>> rtl/core/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and codes of the i2c master transaction sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam int CMP_W = 9;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EVENT = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_TX      = 3'd2,
    ACT_RX_ACK  = 3'd3,
    ACT_RX_NACK = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_RESET   = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_FAULT  = 2'd2
  } err_t;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_RADDR_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] length;
    logic [7:0] byte_value;
    logic [3:0] index;
    logic [7:0] bus_status;
  } req_t;

  typedef struct packed {
    logic       tx_we;
    logic [7:0] tx_waddr;
    logic [7:0] tx_wdata;
    logic       tx_re;
    logic [7:0] tx_raddr;
    logic       rx_we;
    logic [7:0] rx_waddr;
    logic [7:0] rx_wdata;
    logic       rx_re;
    logic [7:0] rx_raddr;
  } mem_req_t;

  typedef struct packed {
    action_t    action;
    logic       tx_sel;
    logic       rx_sel;
    logic       last_ok;
    logic       bus_busy;
    err_t       error_kind;
    logic [7:0] fault_status;
  } info_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       last_ok;
    logic       bus_busy;
    logic [1:0] error_kind;
    logic [7:0] fault_status;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/i2cms_if.sv
// ----------------------------------------------------------------------------
// i2cms request and response channels
// valid/ready channels carrying the request and result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] length;
  logic [7:0] byte_value;
  logic [3:0] index;
  logic [7:0] bus_status;

  modport source (output valid, opcode, length, byte_value, index, bus_status, input ready);
  modport sink (input valid, opcode, length, byte_value, index, bus_status, output ready);
endinterface

interface i2cms_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  logic       last_ok;
  logic       bus_busy;
  logic [1:0] error_kind;
  logic [7:0] fault_status;

  modport source (output valid, action, tx_byte, rx_byte, last_ok, bus_busy, error_kind,
                  fault_status, input ready);
  modport sink (input valid, action, tx_byte, rx_byte, last_ok, bus_busy, error_kind,
                fault_status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/i2c_master_transaction_sequencer_unit.sv
// throughput: one request per cycle, sustained while results are taken
// the decision and buffer access share a single cycle; buffer read data is
// registered, then results wait in a two-entry queue
// reset: synchronous, clears position, length, flags, error and fault codes;
// buffer contents are not cleared
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// sequences i2c master transactions from bus status events
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer_unit
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  i2cms_req_if.sink  req,
  i2cms_rsp_if.source rsp
);

  req_t     r;
  mem_req_t mreq;
  info_t    info;
  info_t    s1_info;
  logic     s1_valid;
  logic     fire;
  logic     pop;
  logic [1:0] cnt;
  logic [7:0] tx_q, rx_q;
  result_t  res;
  result_t  dout;
  logic     out_valid;

  assign r.opcode     = req.opcode;
  assign r.length     = req.length;
  assign r.byte_value = req.byte_value;
  assign r.index      = req.index;
  assign r.bus_status = req.bus_status;

  assign pop       = out_valid & rsp.ready;
  assign req.ready = (3'(cnt) + 3'(s1_valid) < 3'd2) | pop;
  assign fire      = req.valid & req.ready;

  i2cms_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (r),
    .mreq (mreq),
    .info (info)
  );

  i2cms_bufs #(.BUF_DEPTH(BUF_DEPTH)) u_bufs (
    .clk  (clk),
    .mreq (mreq),
    .tx_q (tx_q),
    .rx_q (rx_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_info <= info;
    end
  end

  always_comb begin
    res.action       = s1_info.action;
    res.tx_byte      = s1_info.tx_sel ? tx_q : 8'h00;
    res.rx_byte      = s1_info.rx_sel ? rx_q : 8'h00;
    res.last_ok      = s1_info.last_ok;
    res.bus_busy     = s1_info.bus_busy;
    res.error_kind   = s1_info.error_kind;
    res.fault_status = s1_info.fault_status;
  end

  i2cms_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .din       (res),
    .pop       (pop),
    .out_valid (out_valid),
    .dout      (dout),
    .cnt       (cnt)
  );

  assign rsp.valid        = out_valid;
  assign rsp.action       = dout.action;
  assign rsp.tx_byte      = dout.tx_byte;
  assign rsp.rx_byte      = dout.rx_byte;
  assign rsp.last_ok      = dout.last_ok;
  assign rsp.bus_busy     = dout.bus_busy;
  assign rsp.error_kind   = dout.error_kind;
  assign rsp.fault_status = dout.fault_status;

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (cnt != 2'd2) || pop)
    else $error("result queue overflow");

  a_busy_no_error: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_info.bus_busy |-> s1_info.error_kind == ERR_NONE)
    else $error("busy with an error recorded");

  a_ok_not_busy: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_info.last_ok && s1_info.bus_busy))
    else $error("success flagged while busy");

  a_tx_in_progress: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_info.action == ACT_TX |-> s1_info.bus_busy && !s1_info.last_ok)
    else $error("transmit outside a transaction");

endmodule

`default_nettype wire

>>> rtl/core/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// transaction state and per-request decision, drives buffer accesses
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire req_t     req,
  output mem_req_t      mreq,
  output info_t         info
);

  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam int LW = $clog2(BUF_DEPTH);

  logic [PW-1:0] pos, pos_next;
  logic [LW-1:0] msg_len, msg_len_next;
  logic          ok, ok_next;
  logic          busy, busy_next;
  err_t          err, err_next;
  logic [7:0]    fault, fault_next;

  logic [PW-1:0] pos_eff;
  logic [PW-1:0] pos_inc;
  logic [PW:0]   ack_cmp;
  logic          pos_in;
  logic          idx_in;
  action_t       act;
  logic          tx_sel, rx_sel;
  mem_req_t      m;

  always_comb begin
    pos_eff = (req.bus_status == ST_START || req.bus_status == ST_RESTART) ? '0 : pos;
    pos_in  = pos < PW'(BUF_DEPTH);
    pos_inc = pos_in ? pos + PW'(1) : pos;
    idx_in  = CMP_W'(req.index) < CMP_W'(BUF_DEPTH);
    ack_cmp = (PW+1)'(pos) + (PW+1)'(1);

    pos_next     = pos;
    msg_len_next = msg_len;
    ok_next      = ok;
    busy_next    = busy;
    err_next     = err;
    fault_next   = fault;
    act          = ACT_NONE;
    tx_sel       = 1'b0;
    rx_sel       = 1'b0;
    m            = '0;

    unique case (opcode_t'(req.opcode))
      OP_BEGIN: begin
        if (!busy) begin
          if (CMP_W'(req.length) < CMP_W'(BUF_DEPTH)) begin
            msg_len_next = LW'(req.length);
            m.tx_we      = 1'b1;
            m.tx_waddr   = '0;
            m.tx_wdata   = req.byte_value;
            err_next     = ERR_NONE;
            busy_next    = 1'b1;
            act          = ACT_START;
          end else begin
            err_next = ERR_LENGTH;
          end
          ok_next = 1'b0;
        end
      end
      OP_LOAD: begin
        if (idx_in) begin
          m.tx_we    = 1'b1;
          m.tx_waddr = 8'(req.index);
          m.tx_wdata = req.byte_value;
        end
      end
      OP_EVENT: begin
        if (busy) begin
          unique case (req.bus_status) inside
            ST_START, ST_RESTART, ST_ADDR_ACK, ST_DATA_ACK: begin
              if (pos_eff < PW'(msg_len) && pos_eff < PW'(BUF_DEPTH)) begin
                m.tx_re  = 1'b1;
                m.tx_raddr = 8'(pos_eff);
                tx_sel   = 1'b1;
                pos_next = pos_eff + PW'(1);
                act      = ACT_TX;
              end else begin
                pos_next  = pos_eff;
                ok_next   = 1'b1;
                busy_next = 1'b0;
                act       = ACT_STOP;
              end
            end
            ST_RADDR_ACK: begin
              act = (ack_cmp < (PW+1)'(msg_len)) ? ACT_RX_ACK : ACT_RX_NACK;
            end
            ST_RX_ACK: begin
              if (pos_in) begin
                m.rx_we    = 1'b1;
                m.rx_waddr = 8'(pos);
                m.rx_wdata = req.byte_value;
              end
              pos_next = pos_inc;
              act = ((PW+1)'(pos_inc) + (PW+1)'(1) < (PW+1)'(msg_len)) ? ACT_RX_ACK
                                                                        : ACT_RX_NACK;
            end
            ST_RX_NACK: begin
              if (pos_in) begin
                m.rx_we    = 1'b1;
                m.rx_waddr = 8'(pos);
                m.rx_wdata = req.byte_value;
              end
              ok_next   = 1'b1;
              busy_next = 1'b0;
              act       = ACT_STOP;
            end
            ST_ARB_LOST: begin
              act = ACT_START;
            end
            default: begin
              fault_next = req.bus_status;
              err_next   = ERR_FAULT;
              busy_next  = 1'b0;
              act        = ACT_RESET;
            end
          endcase
        end
      end
      OP_READ: begin
        if (ok && idx_in) begin
          m.rx_re    = 1'b1;
          m.rx_raddr = 8'(req.index);
          rx_sel     = 1'b1;
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    mreq       = m;
    mreq.tx_we = m.tx_we & fire;
    mreq.tx_re = m.tx_re & fire;
    mreq.rx_we = m.rx_we & fire;
    mreq.rx_re = m.rx_re & fire;

    info.action       = act;
    info.tx_sel       = tx_sel;
    info.rx_sel       = rx_sel;
    info.last_ok      = ok_next;
    info.bus_busy     = busy_next;
    info.error_kind   = err_next;
    info.fault_status = fault_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      msg_len <= '0;
      ok      <= 1'b0;
      busy    <= 1'b0;
      err     <= ERR_NONE;
      fault   <= '0;
    end else if (fire) begin
      pos     <= pos_next;
      msg_len <= msg_len_next;
      ok      <= ok_next;
      busy    <= busy_next;
      err     <= err_next;
      fault   <= fault_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/i2cms_bufs.sv
// ----------------------------------------------------------------------------
// i2cms_bufs
// transmit and receive byte buffers, one write and one registered read each
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_bufs
  import i2cms_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire mem_req_t   mreq,
  output logic [7:0]      tx_q,
  output logic [7:0]      rx_q
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [7:0] tx_mem [BUF_DEPTH];
  logic [7:0] rx_mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.tx_we) begin
      tx_mem[mreq.tx_waddr[AW-1:0]] <= mreq.tx_wdata;
    end
    if (mreq.tx_re) begin
      tx_q <= tx_mem[mreq.tx_raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.rx_we) begin
      rx_mem[mreq.rx_waddr[AW-1:0]] <= mreq.rx_wdata;
    end
    if (mreq.rx_re) begin
      rx_q <= rx_mem[mreq.rx_raddr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/i2cms_outq.sv
// ----------------------------------------------------------------------------
// i2cms_outq
// two-entry result queue between the pipeline and the response channel
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_outq
  import i2cms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire result_t  din,
  input  wire logic     pop,
  output logic          out_valid,
  output result_t       dout,
  output logic [1:0]    cnt
);

  result_t q [2];
  logic    wr_ptr;
  logic    rd_ptr;

  assign out_valid = cnt != 2'd0;
  assign dout      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire
